FILE: src/fsme_pkg.sv
// Shared types and constants for the threaded-code execution block.
`default_nettype none

package fsme_pkg;

  localparam int unsigned CELL_BITS  = 32;
  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned DEPTH_BITS = 6;
  localparam int unsigned CMD_BITS   = 4;

  localparam int unsigned DATA_STACK_DEPTH_DEF   = 32;
  localparam int unsigned RETURN_STACK_DEPTH_DEF = 32;
  localparam int unsigned MEM_WORDS_DEF          = 1024;

  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 56;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_EXIT     = 4'd0,
    CMD_COLON    = 4'd1,
    CMD_LITERAL  = 4'd2,
    CMD_DUP      = 4'd3,
    CMD_SWAP     = 4'd4,
    CMD_DROP     = 4'd5,
    CMD_MINUS    = 4'd6,
    CMD_ZEQUAL   = 4'd7,
    CMD_SKIP     = 4'd8,
    CMD_ZSKIP    = 4'd9,
    CMD_VARIABLE = 4'd10,
    CMD_FETCH    = 4'd11,
    CMD_STORE    = 4'd12
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_ADDR  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: src/fsme_stack_ram.sv
// Stack storage: one write port, one registered read port with write forwarding.
`default_nettype none

module fsme_stack_ram #(
  parameter int unsigned WIDTH = fsme_pkg::CELL_BITS,
  parameter int unsigned DEPTH = fsme_pkg::DATA_STACK_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data;
  logic             fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q     <= mem[raddr];
      fwd_data <= wdata;
    end
  end

  // A read that lands on the entry being written in the same cycle sees the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (re) begin
      fwd_hit <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

`default_nettype wire

FILE: src/fsme_dmem.sv
// Cell data memory with a clearing sweep after reset.
`default_nettype none

module fsme_dmem #(
  parameter int unsigned MEM_WORDS = fsme_pkg::MEM_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          we,
  input  wire logic [$clog2(MEM_WORDS)-1:0]  waddr,
  input  wire logic [fsme_pkg::CELL_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(MEM_WORDS)-1:0]  raddr,
  output logic      [fsme_pkg::CELL_BITS-1:0] rdata,
  output logic                               clear_busy
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [fsme_pkg::CELL_BITS-1:0] mem [MEM_WORDS];
  logic [AW-1:0]                  clr_idx;
  logic                           mem_we;
  logic [AW-1:0]                  mem_wa;
  logic [fsme_pkg::CELL_BITS-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_idx    <= '0;
    end else if (clear_busy) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(MEM_WORDS - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  assign mem_we = clear_busy || we;
  assign mem_wa = clear_busy ? clr_idx : waddr;
  assign mem_wd = clear_busy ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/forth_stack_machine_execute.sv
// Threaded-code primitive executor: one primitive per input beat, one result beat out.
// The top of the data stack lives in a register and the cells below it in a stack
// memory read through two ports; the return stack and the data memory are memories
// with a registered read. Most commands execute from the registered beat, and the
// next beat is accepted in the same cycle as that command retires, so a stream of
// them runs at one beat per cycle while no result beat waits; fetch passes through
// the run, address and load states and store through run and address, because the
// memory index is reduced over one registered multiply stage before the data memory
// port is used, and the input only opens in the cycle after either of them retires.
// A result beat that waits on m_axis_tready holds the command behind it. After reset
// the data memory is swept to zero, which keeps the input closed until the sweep ends.
// Stack underflow or overflow reports fault and halted with next_ip zero and leaves
// all state as it was.
`default_nettype none

module forth_stack_machine_execute #(
  parameter int unsigned DATA_STACK_DEPTH   = fsme_pkg::DATA_STACK_DEPTH_DEF,
  parameter int unsigned RETURN_STACK_DEPTH = fsme_pkg::RETURN_STACK_DEPTH_DEF,
  parameter int unsigned MEM_WORDS          = fsme_pkg::MEM_WORDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // cur_ip [15:0], operand [47:16]
  input  wire logic [fsme_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // cmd [3:0]
  input  wire logic [fsme_pkg::CMD_BITS-1:0]       s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // next_ip [15:0], halted [16], top_of_stack [48:17], stack_depth [54:49], fault [55]
  output logic      [fsme_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  localparam int unsigned CW  = fsme_pkg::CELL_BITS;
  localparam int unsigned IPW = fsme_pkg::ADDR_BITS;
  localparam int unsigned DAW = $clog2(DATA_STACK_DEPTH);
  localparam int unsigned DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int unsigned RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int unsigned RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned MAW = $clog2(MEM_WORDS);
  localparam logic [31:0] MemRecip = 32'((64'd1 << 32) / MEM_WORDS);
  localparam logic [16:0] MemSize  = 17'(MEM_WORDS);

  fsme_pkg::state_t st;
  fsme_pkg::cmd_t   ex_cmd;
  logic             ex_valid;
  logic [IPW-1:0]   ex_ip;
  logic [CW-1:0]    ex_opnd;

  logic [CW-1:0]    tos;
  logic [DDW-1:0]   dep;
  logic [RDW-1:0]   rdep;
  logic [15:0]      q_est;

  logic             out_valid;
  logic [IPW-1:0]   o_next;
  logic             o_halt;
  logic [CW-1:0]    o_tos;
  logic [fsme_pkg::DEPTH_BITS-1:0] o_dep;
  logic             o_fault;

  logic [CW-1:0]    tos_next;
  logic [DDW-1:0]   dep_next;
  logic [RDW-1:0]   rdep_next;
  logic [IPW-1:0]   nip;
  logic             flt;
  logic             to_mem;
  logic             done;
  logic             out_free;
  logic             accept;

  logic             ds_we;
  logic [DAW-1:0]   ds_wa;
  logic             rs_we;
  logic             dm_we;
  logic             dm_re;
  logic             clear_busy;

  logic [CW-1:0]    nos;
  logic [CW-1:0]    third;
  logic [IPW-1:0]   rtop;
  logic [CW-1:0]    dm_rdata;

  logic [DDW-1:0]   dep_m1;
  logic [DDW-1:0]   dep_m2;
  logic [DDW-1:0]   dep_sel;
  logic [DDW-1:0]   sel_m2;
  logic [DDW-1:0]   sel_m3;
  logic [RDW-1:0]   rdep_sel;
  logic [RDW-1:0]   rsel_m1;
  logic [IPW-1:0]   ip_inc;
  logic [IPW-1:0]   ip_skip;
  logic [47:0]      q_prod;
  logic [32:0]      qm;
  logic [32:0]      rem_raw;
  logic [16:0]      rem_fix;
  logic [MAW-1:0]   mem_idx;

  assign out_free = !out_valid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st == fsme_pkg::ST_RUN) && (!ex_valid || done);

  assign dep_m1  = dep - DDW'(1);
  assign dep_m2  = dep - DDW'(2);
  assign ip_inc  = ex_ip + IPW'(1);
  assign ip_skip = ex_ip + ex_opnd[IPW-1:0] + IPW'(1);

  // Memory index of the top cell: reciprocal estimate, then one correcting subtract.
  assign q_prod  = 48'(tos[IPW-1:0]) * 48'(MemRecip);
  assign qm      = 33'(q_est) * 33'(MemSize);
  assign rem_raw = 33'(tos[IPW-1:0]) - qm;
  assign rem_fix = (rem_raw[16:0] >= MemSize) ? rem_raw[16:0] - MemSize : rem_raw[16:0];
  assign mem_idx = rem_fix[MAW-1:0];

  always_comb begin
    tos_next  = tos;
    dep_next  = dep;
    rdep_next = rdep;
    nip       = ex_ip;
    flt       = 1'b0;
    to_mem    = 1'b0;
    ds_we     = 1'b0;
    ds_wa     = dep_m1[DAW-1:0];
    rs_we     = 1'b0;
    dm_we     = 1'b0;
    dm_re     = 1'b0;
    done      = 1'b0;
    if (st == fsme_pkg::ST_RUN && ex_valid) begin
      case (ex_cmd)
        fsme_pkg::CMD_EXIT: begin
          if (rdep == '0) begin
            flt = 1'b1;
          end else begin
            rdep_next = rdep - RDW'(1);
            nip       = rtop;
          end
        end
        fsme_pkg::CMD_COLON: begin
          if (rdep == RDW'(RETURN_STACK_DEPTH)) begin
            flt = 1'b1;
          end else begin
            rs_we     = 1'b1;
            rdep_next = rdep + RDW'(1);
            nip       = ex_opnd[IPW-1:0];
          end
        end
        fsme_pkg::CMD_LITERAL, fsme_pkg::CMD_VARIABLE: begin
          if (dep == DDW'(DATA_STACK_DEPTH)) begin
            flt = 1'b1;
          end else begin
            ds_we    = (dep != '0);
            tos_next = ex_opnd;
            dep_next = dep + DDW'(1);
            if (ex_cmd == fsme_pkg::CMD_LITERAL) begin
              nip = ip_inc;
            end
          end
        end
        fsme_pkg::CMD_DUP: begin
          if (dep == '0 || dep == DDW'(DATA_STACK_DEPTH)) begin
            flt = 1'b1;
          end else begin
            ds_we    = 1'b1;
            dep_next = dep + DDW'(1);
          end
        end
        fsme_pkg::CMD_SWAP: begin
          if (dep < DDW'(2)) begin
            flt = 1'b1;
          end else begin
            ds_we    = 1'b1;
            ds_wa    = dep_m2[DAW-1:0];
            tos_next = nos;
          end
        end
        fsme_pkg::CMD_DROP: begin
          if (dep == '0) begin
            flt = 1'b1;
          end else begin
            dep_next = dep_m1;
            tos_next = nos;
          end
        end
        fsme_pkg::CMD_MINUS: begin
          if (dep < DDW'(2)) begin
            flt = 1'b1;
          end else begin
            dep_next = dep_m1;
            tos_next = nos - tos;
          end
        end
        fsme_pkg::CMD_ZEQUAL: begin
          if (dep == '0) begin
            flt = 1'b1;
          end else begin
            tos_next = (tos == '0) ? '1 : '0;
          end
        end
        fsme_pkg::CMD_SKIP: begin
          nip = ip_skip;
        end
        fsme_pkg::CMD_ZSKIP: begin
          if (dep == '0) begin
            flt = 1'b1;
          end else begin
            dep_next = dep_m1;
            tos_next = nos;
            nip      = (tos == '0) ? ip_skip : ip_inc;
          end
        end
        fsme_pkg::CMD_FETCH: begin
          if (dep == '0) begin
            flt = 1'b1;
          end else begin
            to_mem = 1'b1;
          end
        end
        fsme_pkg::CMD_STORE: begin
          if (dep < DDW'(2)) begin
            flt = 1'b1;
          end else begin
            to_mem = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (flt) begin
        nip = '0;
      end
      done = !to_mem && out_free;
      if (!done) begin
        ds_we = 1'b0;
        rs_we = 1'b0;
      end
    end else if (st == fsme_pkg::ST_ADDR) begin
      if (ex_cmd == fsme_pkg::CMD_FETCH) begin
        dm_re = 1'b1;
      end else if (out_free) begin
        dm_we    = 1'b1;
        tos_next = third;
        dep_next = dep_m2;
        done     = 1'b1;
      end
    end else if (st == fsme_pkg::ST_LOAD) begin
      if (out_free) begin
        tos_next = dm_rdata;
        done     = 1'b1;
      end
    end
  end

  // Read addresses for a newly accepted beat follow the stack as the retiring beat leaves it.
  assign dep_sel  = done ? dep_next : dep;
  assign sel_m2   = dep_sel - DDW'(2);
  assign sel_m3   = dep_sel - DDW'(3);
  assign rdep_sel = done ? rdep_next : rdep;
  assign rsel_m1  = rdep_sel - RDW'(1);

  fsme_stack_ram #(.WIDTH(CW), .DEPTH(DATA_STACK_DEPTH)) u_ds_nos (
    .clk   (clk),
    .rst   (rst),
    .we    (ds_we),
    .waddr (ds_wa),
    .wdata (tos),
    .re    (accept),
    .raddr (sel_m2[DAW-1:0]),
    .rdata (nos)
  );

  fsme_stack_ram #(.WIDTH(CW), .DEPTH(DATA_STACK_DEPTH)) u_ds_third (
    .clk   (clk),
    .rst   (rst),
    .we    (ds_we),
    .waddr (ds_wa),
    .wdata (tos),
    .re    (accept),
    .raddr (sel_m3[DAW-1:0]),
    .rdata (third)
  );

  fsme_stack_ram #(.WIDTH(IPW), .DEPTH(RETURN_STACK_DEPTH)) u_rs (
    .clk   (clk),
    .rst   (rst),
    .we    (rs_we),
    .waddr (rdep[RAW-1:0]),
    .wdata (ex_ip),
    .re    (accept),
    .raddr (rsel_m1[RAW-1:0]),
    .rdata (rtop)
  );

  fsme_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk        (clk),
    .rst        (rst),
    .we         (dm_we),
    .waddr      (mem_idx),
    .wdata      (nos),
    .re         (dm_re),
    .raddr      (mem_idx),
    .rdata      (dm_rdata),
    .clear_busy (clear_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= fsme_pkg::ST_CLEAR;
      ex_valid <= 1'b0;
      dep      <= '0;
      rdep     <= '0;
    end else begin
      case (st)
        fsme_pkg::ST_CLEAR: begin
          if (!clear_busy) begin
            st <= fsme_pkg::ST_RUN;
          end
        end
        fsme_pkg::ST_RUN: begin
          if (ex_valid && to_mem) begin
            st <= fsme_pkg::ST_ADDR;
          end
        end
        fsme_pkg::ST_ADDR: begin
          if (ex_cmd == fsme_pkg::CMD_FETCH) begin
            st <= fsme_pkg::ST_LOAD;
          end else if (done) begin
            st <= fsme_pkg::ST_RUN;
          end
        end
        fsme_pkg::ST_LOAD: begin
          if (done) begin
            st <= fsme_pkg::ST_RUN;
          end
        end
        default: begin
          st <= fsme_pkg::ST_CLEAR;
        end
      endcase
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (done) begin
        ex_valid <= 1'b0;
      end
      if (done) begin
        dep  <= dep_next;
        rdep <= rdep_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_est <= q_prod[47:32];
    if (done) begin
      tos <= tos_next;
    end
    if (accept) begin
      ex_cmd  <= fsme_pkg::cmd_t'(s_axis_tuser);
      ex_ip   <= s_axis_tdata[IPW-1:0];
      ex_opnd <= s_axis_tdata[IPW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      o_next  <= nip;
      o_halt  <= flt || (nip == '0);
      o_tos   <= (dep_next != '0) ? tos_next : '0;
      o_dep   <= fsme_pkg::DEPTH_BITS'(dep_next);
      o_fault <= flt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {o_fault, o_dep, o_tos, o_halt, o_next};

  a_dep_bound: assert property (@(posedge clk) disable iff (rst)
    dep <= DDW'(DATA_STACK_DEPTH))
    else $error("data stack depth beyond its bound");

  a_rdep_bound: assert property (@(posedge clk) disable iff (rst)
    rdep <= RDW'(RETURN_STACK_DEPTH))
    else $error("return stack depth beyond its bound");

  a_fault_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && flt) |=> (dep == $past(dep)) && (rdep == $past(rdep)) && (tos == $past(tos)))
    else $error("faulting command changed the stacks");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    (st == fsme_pkg::ST_LOAD) |-> ($past(st) == fsme_pkg::ST_ADDR ||
                                    $past(st) == fsme_pkg::ST_LOAD))
    else $error("load cycle entered without an address cycle");

  a_no_accept_mem: assert property (@(posedge clk) disable iff (rst)
    (st == fsme_pkg::ST_ADDR || st == fsme_pkg::ST_LOAD) |-> !s_axis_tready)
    else $error("input opened during a data memory access");

endmodule

`default_nettype wire

FILE: bench/forth_stack_machine_execute_test.sv
// Self-checking testbench for the threaded-code primitive executor.
module forth_stack_machine_execute_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned DSTACK_CELLS = fsme_pkg::DATA_STACK_DEPTH_DEF;
  localparam int unsigned RSTACK_CELLS = fsme_pkg::RETURN_STACK_DEPTH_DEF;
  localparam int unsigned MEM_CELLS    = fsme_pkg::MEM_WORDS_DEF;
  localparam int unsigned STIM_ITEMS   = 1130;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned REPORT_LIMIT = 10;

  // Command codes above the last primitive are treated as no-ops by the block.
  localparam logic [fsme_pkg::CMD_BITS-1:0] CMD_SPARE_FIRST = 4'd13;
  localparam int unsigned CMD_CODES = 1 << fsme_pkg::CMD_BITS;

  typedef struct {
    logic [fsme_pkg::CMD_BITS-1:0]  op;
    logic [fsme_pkg::ADDR_BITS-1:0] ip;
    logic [fsme_pkg::CELL_BITS-1:0] opnd;
  } instr_t;

  typedef struct {
    logic [fsme_pkg::ADDR_BITS-1:0]  next_ip;
    logic                            halted;
    logic [fsme_pkg::CELL_BITS-1:0]  tos;
    logic [fsme_pkg::DEPTH_BITS-1:0] depth;
    logic                            fault;
  } result_t;

  typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED, BIAS_NEST, BIAS_UNWIND} bias_t;
  typedef enum {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [fsme_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [fsme_pkg::CMD_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [fsme_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

  forth_stack_machine_execute i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Shadow machine state.
  logic [fsme_pkg::CELL_BITS-1:0] dstk [DSTACK_CELLS];
  logic [fsme_pkg::ADDR_BITS-1:0] rstk [RSTACK_CELLS];
  logic [fsme_pkg::CELL_BITS-1:0] dmem [MEM_CELLS];
  int unsigned dsp = 0;
  int unsigned rsp = 0;

  instr_t  instr_queue[$];
  result_t results_due[$];

  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned results_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned halts_seen = 0;
  int unsigned deepest = 0;
  int unsigned cycles = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0] rx_pos = '0;

  function automatic result_t execute_primitive(
      input logic [fsme_pkg::CMD_BITS-1:0] op,
      input logic [fsme_pkg::ADDR_BITS-1:0] ip,
      input logic [fsme_pkg::CELL_BITS-1:0] opnd);
    result_t res;
    logic [fsme_pkg::ADDR_BITS-1:0] nxt;
    logic flt;
    logic [fsme_pkg::CELL_BITS-1:0] tmp;
    int unsigned d;
    nxt = ip;
    flt = 1'b0;
    d = dsp;
    case (op)
      fsme_pkg::CMD_EXIT: begin
        if (rsp < 1) flt = 1'b1;
        else begin
          rsp = rsp - 1;
          nxt = rstk[rsp];
        end
      end
      fsme_pkg::CMD_COLON: begin
        if (rsp >= RSTACK_CELLS) flt = 1'b1;
        else begin
          rstk[rsp] = ip;
          rsp = rsp + 1;
          nxt = opnd[fsme_pkg::ADDR_BITS-1:0];
        end
      end
      fsme_pkg::CMD_LITERAL, fsme_pkg::CMD_VARIABLE: begin
        if (d >= DSTACK_CELLS) flt = 1'b1;
        else begin
          dstk[d] = opnd;
          dsp = d + 1;
          if (op == fsme_pkg::CMD_LITERAL) nxt = ip + 1'b1;
        end
      end
      fsme_pkg::CMD_DUP: begin
        if (d < 1 || d >= DSTACK_CELLS) flt = 1'b1;
        else begin
          dstk[d] = dstk[d-1];
          dsp = d + 1;
        end
      end
      fsme_pkg::CMD_SWAP: begin
        if (d < 2) flt = 1'b1;
        else begin
          tmp = dstk[d-1];
          dstk[d-1] = dstk[d-2];
          dstk[d-2] = tmp;
        end
      end
      fsme_pkg::CMD_DROP: begin
        if (d < 1) flt = 1'b1;
        else dsp = d - 1;
      end
      fsme_pkg::CMD_MINUS: begin
        if (d < 2) flt = 1'b1;
        else begin
          dstk[d-2] = dstk[d-2] - dstk[d-1];
          dsp = d - 1;
        end
      end
      fsme_pkg::CMD_ZEQUAL: begin
        if (d < 1) flt = 1'b1;
        else dstk[d-1] = (dstk[d-1] == '0) ? '1 : '0;
      end
      fsme_pkg::CMD_SKIP: nxt = ip + opnd[fsme_pkg::ADDR_BITS-1:0] + 1'b1;
      fsme_pkg::CMD_ZSKIP: begin
        if (d < 1) flt = 1'b1;
        else begin
          dsp = d - 1;
          if (dstk[d-1] == '0) nxt = ip + opnd[fsme_pkg::ADDR_BITS-1:0] + 1'b1;
          else nxt = ip + 1'b1;
        end
      end
      fsme_pkg::CMD_FETCH: begin
        if (d < 1) flt = 1'b1;
        else dstk[d-1] = dmem[dstk[d-1][fsme_pkg::ADDR_BITS-1:0] % MEM_CELLS];
      end
      fsme_pkg::CMD_STORE: begin
        if (d < 2) flt = 1'b1;
        else begin
          dmem[dstk[d-1][fsme_pkg::ADDR_BITS-1:0] % MEM_CELLS] = dstk[d-2];
          dsp = d - 2;
        end
      end
      default: ;
    endcase
    if (flt) nxt = '0;
    res.next_ip = nxt;
    res.halted = flt || (nxt == '0);
    res.tos = (dsp > 0) ? dstk[dsp-1] : '0;
    res.depth = dsp[fsme_pkg::DEPTH_BITS-1:0];
    res.fault = flt;
    return res;
  endfunction

  task automatic push_instr(input logic [fsme_pkg::CMD_BITS-1:0] op,
                            input logic [fsme_pkg::ADDR_BITS-1:0] ip,
                            input logic [fsme_pkg::CELL_BITS-1:0] opnd);
    instr_t it;
    it.op = op;
    it.ip = ip;
    it.opnd = opnd;
    instr_queue.push_back(it);
  endtask

  function automatic logic [fsme_pkg::ADDR_BITS-1:0] rand_ip();
    return ($urandom_range(0, 15) == 0) ? '1 : fsme_pkg::ADDR_BITS'($urandom);
  endfunction

  function automatic logic [fsme_pkg::CELL_BITS-1:0] rand_cell();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // A few memory cells are reused so that fetches often read back what a store wrote.
  // The bits above the index are random, since the block must ignore them.
  function automatic logic [fsme_pkg::CELL_BITS-1:0] rand_mem_addr();
    logic [fsme_pkg::CELL_BITS-1:0] a;
    a = $urandom;
    a[9:0] = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 3))
                                         : 10'(MEM_CELLS - 1 - $urandom_range(0, 3));
    return a;
  endfunction

  function automatic logic [fsme_pkg::CMD_BITS-1:0] pick_single(input bias_t bias);
    if ($urandom_range(0, 3) == 0) begin
      return fsme_pkg::CMD_BITS'($urandom_range(0, CMD_CODES - 1));
    end
    case (bias)
      BIAS_FILL: begin
        case ($urandom_range(0, 3))
          0: return fsme_pkg::CMD_LITERAL;
          1: return fsme_pkg::CMD_VARIABLE;
          2: return fsme_pkg::CMD_DUP;
          default: return fsme_pkg::CMD_COLON;
        endcase
      end
      BIAS_DRAIN: begin
        case ($urandom_range(0, 4))
          0: return fsme_pkg::CMD_DROP;
          1: return fsme_pkg::CMD_MINUS;
          2: return fsme_pkg::CMD_STORE;
          3: return fsme_pkg::CMD_ZSKIP;
          default: return fsme_pkg::CMD_EXIT;
        endcase
      end
      BIAS_NEST: return fsme_pkg::CMD_COLON;
      BIAS_UNWIND: return fsme_pkg::CMD_EXIT;
      default: return fsme_pkg::CMD_BITS'($urandom_range(0, CMD_CODES - 1));
    endcase
  endfunction

  task automatic add_random_unit(input bias_t bias);
    int unsigned pick;
    logic [fsme_pkg::CELL_BITS-1:0] addr;
    addr = rand_mem_addr();
    pick = $urandom_range(0, 9);
    if ((bias == BIAS_NEST || bias == BIAS_UNWIND) && $urandom_range(0, 6) != 0) pick = 9;
    case (pick)
      0: begin
        push_instr(fsme_pkg::CMD_LITERAL, rand_ip(), rand_cell());
        push_instr(fsme_pkg::CMD_VARIABLE, rand_ip(), addr);
        push_instr(fsme_pkg::CMD_STORE, rand_ip(), $urandom);
      end
      1: begin
        push_instr(fsme_pkg::CMD_VARIABLE, rand_ip(), addr);
        push_instr(fsme_pkg::CMD_FETCH, rand_ip(), $urandom);
      end
      2: begin
        push_instr(fsme_pkg::CMD_LITERAL, rand_ip(), rand_cell());
        push_instr(fsme_pkg::CMD_LITERAL, rand_ip(), rand_cell());
        push_instr(($urandom_range(0, 1) == 0) ? fsme_pkg::CMD_MINUS : fsme_pkg::CMD_SWAP,
                   rand_ip(), $urandom);
      end
      3: begin
        push_instr(fsme_pkg::CMD_LITERAL, rand_ip(),
                   ($urandom_range(0, 1) == 0) ? '0 : rand_cell());
        push_instr(fsme_pkg::CMD_ZSKIP, rand_ip(), $urandom);
      end
      4: begin
        push_instr(fsme_pkg::CMD_DUP, rand_ip(), $urandom);
        push_instr(fsme_pkg::CMD_ZEQUAL, rand_ip(), $urandom);
      end
      default: push_instr(pick_single(bias), rand_ip(), $urandom);
    endcase
  endtask

  initial begin
    bias_t bias;
    int unsigned seg;
    foreach (dmem[i]) dmem[i] = '0;

    // Directed opening: underflow on empty stacks, wraps to address zero, every primitive.
    push_instr(fsme_pkg::CMD_EXIT, 16'h1000, 32'h0);
    push_instr(fsme_pkg::CMD_DROP, 16'h1001, 32'h0);
    push_instr(fsme_pkg::CMD_LITERAL, 16'hFFFF, 32'h0);
    push_instr(fsme_pkg::CMD_ZEQUAL, 16'h0002, 32'h0);
    push_instr(fsme_pkg::CMD_ZEQUAL, 16'h0003, 32'hFFFF_FFFF);
    push_instr(fsme_pkg::CMD_LITERAL, 16'h0000, 32'hFFFF_FFFF);
    push_instr(fsme_pkg::CMD_DUP, 16'h0005, 32'h0);
    push_instr(fsme_pkg::CMD_MINUS, 16'h0006, 32'h0);
    push_instr(fsme_pkg::CMD_LITERAL, 16'h8000, 32'h0000_0001);
    push_instr(fsme_pkg::CMD_SWAP, 16'h0008, 32'h0);
    push_instr(fsme_pkg::CMD_LITERAL, 16'h7FFF, 32'hDEAD_BEEF);
    push_instr(fsme_pkg::CMD_VARIABLE, 16'h000A, 32'hFFFF_FC05);
    push_instr(fsme_pkg::CMD_STORE, 16'h000B, 32'h0);
    push_instr(fsme_pkg::CMD_VARIABLE, 16'h000C, 32'h0000_0005);
    push_instr(fsme_pkg::CMD_FETCH, 16'h000D, 32'h0);
    push_instr(fsme_pkg::CMD_SKIP, 16'h1234, 32'hFFFF_FFFF);
    push_instr(fsme_pkg::CMD_SKIP, 16'hFFFF, 32'h0);
    push_instr(fsme_pkg::CMD_ZSKIP, 16'h0010, 32'h0000_0040);
    push_instr(fsme_pkg::CMD_LITERAL, 16'h0011, 32'h0);
    push_instr(fsme_pkg::CMD_ZSKIP, 16'h0012, 32'h7FFF_FFFE);
    push_instr(fsme_pkg::CMD_COLON, 16'h0000, 32'hABCD_FFFF);
    push_instr(fsme_pkg::CMD_COLON, 16'h4321, 32'h0);
    push_instr(fsme_pkg::CMD_EXIT, 16'h0015, 32'h0);
    push_instr(fsme_pkg::CMD_EXIT, 16'h0016, 32'h0);
    for (int i = 0; i < 3; i++) begin
      push_instr(CMD_SPARE_FIRST + fsme_pkg::CMD_BITS'(i), rand_ip(), $urandom);
    end

    // Random part in segments that push, pop, nest, unwind or mix, so both stacks reach their limits.
    while (instr_queue.size() < STIM_ITEMS) begin
      bias = bias_t'($urandom_range(0, 4));
      seg = $urandom_range(10, 60);
      repeat (seg) begin
        if (instr_queue.size() < STIM_ITEMS) add_random_unit(bias);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (instr_queue.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d expected results never arrived", results_due.size());
      errors += results_due.size();
    end

    $display("Executed %0d primitives and checked %0d results in %0d cycles.",
             beats_in, results_seen, cycles);
    $display("Seen: %0d stack faults, %0d halts, data stack depth up to %0d.",
             faults_seen, halts_seen, deepest);
    if (errors == 0) begin
      $display("forth_stack_machine_execute_test: done, clean");
    end else begin
      $display("forth_stack_machine_execute_test: done, errors");
    end
    $finish;
  end

  // Sender: bursts of random length, with random gaps and the odd long unbroken run.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(execute_primitive(instr_queue[0].op, instr_queue[0].ip,
                                                instr_queue[0].opnd));
        void'(instr_queue.pop_front());
        beats_in++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (instr_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {instr_queue[0].opnd, instr_queue[0].ip};
          s_axis_tuser <= instr_queue[0].op;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each beat and stalls by fully open, rotating-pattern or random phases.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_t got;
        result_t want;
        got.next_ip = m_axis_tdata[15:0];
        got.halted  = m_axis_tdata[16];
        got.tos     = m_axis_tdata[48:17];
        got.depth   = m_axis_tdata[54:49];
        got.fault   = m_axis_tdata[55];
        results_seen++;
        if (got.fault) faults_seen++;
        if (got.halted) halts_seen++;
        if (got.depth > deepest) deepest = got.depth;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result beat: next_ip %h tos %h depth %0d", got.next_ip,
                     got.tos, got.depth);
        end else begin
          want = results_due.pop_front();
          if (got.next_ip !== want.next_ip || got.halted !== want.halted ||
              got.tos !== want.tos || got.depth !== want.depth || got.fault !== want.fault)
          begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"result %0d: next_ip %h/%h halted %b/%b tos %h/%h ",
                        "depth %0d/%0d fault %b/%b (expected/actual)"},
                       results_seen, want.next_ip, got.next_ip, want.halted, got.halted,
                       want.tos, got.tos, want.depth, got.depth, want.fault, got.fault);
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 300);
        rx_pattern = 16'($urandom) | 16'h0001;
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN: m_axis_tready <= 1'b1;
        RX_PATTERN: m_axis_tready <= rx_pattern[rx_pos];
        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
      rx_pos <= rx_pos + 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("forth_stack_machine_execute_test: done, errors");
      $finish;
    end
  end

endmodule

FILE: forth_stack_machine_execute.f
src/fsme_pkg.sv
src/fsme_stack_ram.sv
src/fsme_dmem.sv
src/forth_stack_machine_execute.sv
bench/forth_stack_machine_execute_test.sv
